>>> rtl/mobm_pkg.sv
`timescale 1ns / 1ps

package mobm_pkg;

	// Transaction kinds carried in s_axis_tuser.
	typedef enum logic [2:0] {
		KIND_OUTER_WRITE = 3'd0,
		KIND_PRG_XLATE   = 3'd1,
		KIND_CHR_XLATE   = 3'd2,
		KIND_ROM_READ    = 3'd3,
		KIND_SOFT_RESET  = 3'd4
	} kind_t;

	// Outer register indexes.
	localparam logic [1:0] REG_OUTER   = 2'd0;
	localparam logic [1:0] REG_SWITCH  = 2'd1;
	localparam logic [1:0] REG_CNROM   = 2'd2;
	localparam logic [1:0] REG_MODE    = 2'd3;

	// PRG modes in bits 1..0 of the mode register.
	localparam logic [1:0] PRG_MMC3     = 2'd0;
	localparam logic [1:0] PRG_NROM256  = 2'd3;

	// Field positions in the master-side tdata and tuser.
	localparam int unsigned OUT_MAIN_LSB   = 0;
	localparam int unsigned OUT_MAIN_W     = 10;
	localparam int unsigned OUT_MIRROR_LSB = 10;
	localparam int unsigned OUT_MIRROR_W   = 9;
	localparam int unsigned OUT_READ_LSB   = 19;
	localparam int unsigned OUT_READ_W     = 8;
	localparam int unsigned USER_MIRROR_VALID = 0;
	localparam int unsigned USER_CHR_8K       = 1;

	typedef struct packed {
		logic [9:0] bank_main;
		logic [8:0] bank_mirror;
		logic       mirror_valid;
		logic       chr_whole_8k;
		logic [7:0] read_data;
	} result_t;

endpackage

>>> rtl/multicart_outer_bank_mapper.sv
`timescale 1ns / 1ps

// Outer bank mapper for an MMC3-based multicart board.
//
// The slave-side stream carries one transaction per bus event: the kind in
// s_axis_tuser and the address, data byte and MMC3 bank register 6 in
// s_axis_tdata. Every transaction, whatever its kind, yields exactly one
// transaction on the master-side stream with the translated PRG or CHR bank,
// the mirrored PRG bank and the ROM read byte; fields that mean nothing for
// a kind are zero. Outer writes and soft resets update the state.
//
// An accepted transaction is held in an input register, then the bank logic
// updates the state and loads the result register, which drives the
// master-side stream. One transaction is taken in every cycle while the
// receiver does not stall. When the receiver stalls, the result register
// holds and the input register still takes one more transaction before
// s_axis_tready falls.
//
// The configuration channel writes the single swap bit; cfg_ready is always
// high. The asynchronous reset clears the outer registers, the switch
// counter, the swap bit and both valid flags.
module multicart_outer_bank_mapper import mobm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // address[15:0], value[23:16], inner_prg_six[31:24]
	input  logic [2:0]  s_axis_tuser,   // kind[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // bank_main[9:0], bank_mirror[18:10], read_data[26:19]
	output logic [1:0]  m_axis_tuser,   // mirror_valid[0], chr_whole_8k[1]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	logic        valid_s1;
	logic [2:0]  kind_s1;
	logic [15:0] address_s1;
	logic [7:0]  value_s1;
	logic [7:0]  six_s1;

	logic [7:0]  outer_q [4];
	logic [1:0]  switch_q;
	logic        swap_q;
	logic        out_valid_q;
	result_t     result_q;
	result_t     result_c;

	logic advance;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_s1    <= s_axis_tuser;
			address_s1 <= s_axis_tdata[15:0];
			value_s1   <= s_axis_tdata[23:16];
			six_s1     <= s_axis_tdata[31:24];
		end
	end

	// PRG masks
	logic [8:0] prg_and_m;
	logic [8:0] prg_or_m;
	logic [1:0] prg_mode;
	logic [7:0] prg_v;
	logic [7:0] prg_v_mirror;
	// CHR masks
	logic [9:0] chr_and_m;
	logic [9:0] chr_or_m;
	logic [9:0] chr_high;
	logic [7:0] r0;
	logic [7:0] r2;
	logic [7:0] r3;
	logic [7:0] r2_locked;
	logic [7:0] lock_m;

	assign r0 = outer_q[REG_OUTER];
	assign r2 = outer_q[REG_CNROM];
	assign r3 = outer_q[REG_MODE];

	always_comb begin
		prg_and_m = r0[6] ? 9'h00F : 9'h01F;
		prg_or_m  = {r0[5:4], r0[2:0], 4'b0000} & ~prg_and_m;
		prg_mode  = r3[1:0];
		prg_v_mirror = 8'h00;
		if (prg_mode == PRG_MMC3) begin
			prg_v = value_s1;
		end else if (prg_mode == PRG_NROM256) begin
			prg_v        = {six_s1[7:2], address_s1[14:13]};
			prg_v_mirror = prg_v ^ 8'h02;
		end else begin
			prg_v = {six_s1[7:1], address_s1[13]};
		end

		chr_and_m = r0[7] ? 10'h07F : 10'h0FF;
		if (swap_q) begin
			chr_or_m = {r0[4], r0[5], r0[3], 7'b0000000};
		end else begin
			chr_or_m = {r0[5], r0[4], r0[3], 7'b0000000};
		end
		chr_high = chr_or_m & ~chr_and_m;

		lock_m    = r2[4] ? 8'h01 : 8'h03;
		r2_locked = (r2 & ~lock_m) | (value_s1 & lock_m);
	end

	always_comb begin
		result_c = '0;
		case (kind_s1)
			KIND_PRG_XLATE: begin
				result_c.bank_main = {1'b0, ({1'b0, prg_v} & prg_and_m) | prg_or_m};
				if (prg_mode != PRG_MMC3) begin
					result_c.mirror_valid = 1'b1;
					if (prg_mode == PRG_NROM256) begin
						result_c.bank_mirror = ({1'b0, prg_v_mirror} & prg_and_m) | prg_or_m;
					end else begin
						result_c.bank_mirror = ({1'b0, prg_v} & prg_and_m) | prg_or_m;
					end
				end
			end
			KIND_CHR_XLATE: begin
				if (r3[4]) begin
					result_c.chr_whole_8k = 1'b1;
					result_c.bank_main    = ({2'b00, r2} & (chr_and_m >> 3)) | (chr_high >> 3);
				end else begin
					result_c.bank_main = ({2'b00, value_s1} & chr_and_m) | chr_high;
				end
			end
			KIND_ROM_READ: begin
				result_c.read_data = outer_q[REG_SWITCH][0] ?
					{value_s1[7:2], switch_q} : value_s1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_q[0]  <= 8'h00;
			outer_q[1]  <= 8'h00;
			outer_q[2]  <= 8'h00;
			outer_q[3]  <= 8'h00;
			switch_q    <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tready || !out_valid_q) begin
				out_valid_q <= valid_s1;
			end
			if (advance) begin
				case (kind_s1)
					KIND_OUTER_WRITE: begin
						if (!r3[7]) begin
							outer_q[address_s1[1:0]] <= value_s1;
						end else if (address_s1[1:0] == REG_CNROM) begin
							outer_q[REG_CNROM] <= r2_locked;
						end
					end
					KIND_SOFT_RESET: begin
						switch_q   <= switch_q + 2'd1;
						outer_q[0] <= 8'h00;
						outer_q[1] <= 8'h00;
						outer_q[2] <= 8'h00;
						outer_q[3] <= 8'h00;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			swap_q <= cfg_data;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b00000, result_q.read_data, result_q.bank_mirror,
		result_q.bank_main};
	assign m_axis_tuser  = {result_q.chr_whole_8k, result_q.mirror_valid};

endmodule

>>> rtl/mobm_checker.sv
`timescale 1ns / 1ps

module mobm_assertions import mobm_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	logic [OUT_MAIN_W-1:0] bank_main;
	logic [OUT_READ_W-1:0] read_data;
	assign bank_main = m_axis_tdata[OUT_MAIN_LSB +: OUT_MAIN_W];
	assign read_data = m_axis_tdata[OUT_READ_LSB +: OUT_READ_W];

	// A stalled result transaction keeps its payload.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// A mirrored window only comes from PRG translation, whose banks fit in nine bits.
	a_mirror_prg: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[USER_MIRROR_VALID] |->
			!m_axis_tuser[USER_CHR_8K] && !bank_main[9] && read_data == 8'h00)
		else $error("mirror flag on a non-PRG result");

	// A CNROM bank is an 8K bank number of at most seven bits.
	a_cnrom_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[USER_CHR_8K] |->
			bank_main[9:7] == 3'b000 && read_data == 8'h00)
		else $error("CNROM bank out of range");

	// ROM read data never shares a result with a bank number.
	a_read_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && read_data != 8'h00 |->
			bank_main == 10'h000 && m_axis_tuser == 2'b00)
		else $error("read data mixed with bank result");

endmodule

bind multicart_outer_bank_mapper mobm_assertions u_mobm_assertions (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
